@@ hw/rtl/p2c_pkg.sv @@
// ----------------------------------------------------------------------------
// p2c_pkg
// Shared types, register indexes and color decode helpers for the
// planar-to-chunky palette decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package p2c_pkg;

  localparam int unsigned PlaneW   = 16;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned EntryW   = 12;

  localparam logic [1:0] RES_LOW = 2'd0;
  localparam logic [1:0] RES_MED = 2'd1;

  localparam logic [CfgIdxW-1:0] CFG_RESOLUTION = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_COOKIE     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PAL_Q0     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PAL_Q1     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PAL_Q2     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PAL_Q3     = 3'd5;

  typedef logic [3:0][CfgDataW-1:0] pal_t;

  typedef struct packed {
    logic [PlaneW-1:0] w0;
    logic [PlaneW-1:0] w1;
    logic [PlaneW-1:0] w2;
    logic [PlaneW-1:0] w3;
    logic              dbl;
  } item_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
    logic       empty;
  } qstat_t;

  function automatic logic [EntryW-1:0] raw_entry(input pal_t pal, input logic [3:0] idx);
    logic [CfgDataW-1:0] q;
    q = pal[idx[3:2]];
    return q[EntryW*idx[1:0] +: EntryW];
  endfunction

  function automatic logic [7:0] gun_level(input logic [3:0] n, input logic enh);
    logic [3:0] g;
    logic [7:0] lvl;
    g = {n[2:0], n[3]};
    if (enh) begin
      lvl = {g, g};
    end else begin
      case (n[2:0])
        3'd0:    lvl = 8'd0;
        3'd1:    lvl = 8'd36;
        3'd2:    lvl = 8'd72;
        3'd3:    lvl = 8'd109;
        3'd4:    lvl = 8'd145;
        3'd5:    lvl = 8'd182;
        3'd6:    lvl = 8'd218;
        default: lvl = 8'd255;
      endcase
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/p2c_if.sv @@
// ----------------------------------------------------------------------------
// p2c_if
// Valid/ready channels for plane groups in and decoded pixels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface p2c_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] plane_zero_word;
  logic [15:0] plane_one_word;
  logic [15:0] plane_two_word;
  logic [15:0] plane_three_word;

  modport source (output valid, plane_zero_word, plane_one_word, plane_two_word,
                  plane_three_word, input ready);
  modport sink (input valid, plane_zero_word, plane_one_word, plane_two_word,
                plane_three_word, output ready);
endinterface

interface p2c_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] pixel_index;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;
  logic       last_pixel;

  modport source (output valid, pixel_index, red_level, green_level, blue_level,
                  last_pixel, input ready);
  modport sink (input valid, pixel_index, red_level, green_level, blue_level,
                last_pixel, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/planar_to_chunky_palette_decode_top.sv @@
// ----------------------------------------------------------------------------
// planar_to_chunky_palette_decode_top
// Bitplane group to palette-indexed RGB pixel stream.
// ----------------------------------------------------------------------------
// A plane group in low resolution produces 32 pixels (each source pixel
// twice); medium and high resolution produce 16 pixels. The back-end
// sequencer emits one pixel per cycle, unless out.ready holds it, through a
// single registered output stage, which sets that rate. Up to three groups
// can be held at once (input register plus two-entry queue, whose head is the
// group being walked), so input is taken while pixels are still draining.
// Resolution, machine cookie and palette registers may only be written while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_to_chunky_palette_decode_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  p2c_in_if.sink                               in,
  p2c_out_if.source                            out,
  input  wire logic                            cfg_we,
  input  wire logic [p2c_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [p2c_pkg::CfgDataW-1:0]    cfg_data
);

  logic [1:0]       resolution;
  logic [31:0]      machine_cookie;
  p2c_pkg::pal_t    pal;
  logic             push_valid;
  logic             push_ready;
  p2c_pkg::item_t   push_data;
  logic             pop_valid;
  logic             pop_ready;
  p2c_pkg::item_t   pop_data;
  p2c_pkg::qstat_t  qstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution     <= '0;
      machine_cookie <= '0;
      pal            <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        p2c_pkg::CFG_RESOLUTION: resolution     <= cfg_data[1:0];
        p2c_pkg::CFG_COOKIE:     machine_cookie <= cfg_data[31:0];
        p2c_pkg::CFG_PAL_Q0:     pal[0]         <= cfg_data;
        p2c_pkg::CFG_PAL_Q1:     pal[1]         <= cfg_data;
        p2c_pkg::CFG_PAL_Q2:     pal[2]         <= cfg_data;
        p2c_pkg::CFG_PAL_Q3:     pal[3]         <= cfg_data;
        default: ;
      endcase
    end
  end

  p2c_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in         (in),
    .resolution (resolution),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  p2c_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .stat       (qstat)
  );

  p2c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .pal       (pal),
    .enhanced  (machine_cookie[31:16] != 16'd0),
    .out       (out)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count != 2'd3)
    else $error("queue count out of range");

  a_queue_count: assert property (@(posedge clk) disable iff (rst)
    (push_valid && push_ready && !(pop_valid && pop_ready)) |=>
      (qstat.count == $past(qstat.count) + 2'd1))
    else $error("queue count did not follow push");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> (!out.valid && qstat.empty))
    else $error("output or queue not idle after reset");

endmodule

`default_nettype wire

@@ hw/rtl/p2c_front.sv @@
// ----------------------------------------------------------------------------
// p2c_front
// Accepts plane groups, drops planes the resolution does not use and tags
// low-resolution groups for doubling.
// ----------------------------------------------------------------------------
`default_nettype none

module p2c_front (
  input  wire logic              clk,
  input  wire logic              rst,
  p2c_in_if.sink                 in,
  input  wire logic [1:0]        resolution,
  output      logic              push_valid,
  input  wire logic              push_ready,
  output      p2c_pkg::item_t    push_data
);

  logic           fv;
  p2c_pkg::item_t fdata;
  p2c_pkg::item_t item_next;
  logic           use_w1;
  logic           use_w23;

  assign in.ready   = !fv || push_ready;
  assign push_valid = fv;
  assign push_data  = fdata;

  always_comb begin
    use_w23 = (resolution == p2c_pkg::RES_LOW);
    use_w1  = use_w23 || (resolution == p2c_pkg::RES_MED);
    item_next.w0  = in.plane_zero_word;
    item_next.w1  = use_w1  ? in.plane_one_word   : '0;
    item_next.w2  = use_w23 ? in.plane_two_word   : '0;
    item_next.w3  = use_w23 ? in.plane_three_word : '0;
    item_next.dbl = use_w23;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in.valid && in.ready) begin
      fv <= 1'b1;
    end else if (push_ready) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      fdata <= item_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/p2c_fifo.sv @@
// ----------------------------------------------------------------------------
// p2c_fifo
// Two-entry queue of classified plane groups between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module p2c_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output      logic           push_ready,
  input  wire p2c_pkg::item_t push_data,
  output      logic           pop_valid,
  input  wire logic           pop_ready,
  output      p2c_pkg::item_t pop_data,
  output      p2c_pkg::qstat_t stat
);

  p2c_pkg::item_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  assign stat.count = count;
  assign stat.full  = !push_ready;
  assign stat.empty = !pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/p2c_back.sv @@
// ----------------------------------------------------------------------------
// p2c_back
// Walks one plane group a pixel per cycle when the output slot is free, looks
// up the palette entry and registers the decoded pixel for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module p2c_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pop_valid,
  output      logic           pop_ready,
  input  wire p2c_pkg::item_t pop_data,
  input  wire p2c_pkg::pal_t  pal,
  input  wire logic           enhanced,
  p2c_out_if.source           out
);

  logic                           ov;
  logic [4:0]                     cnt;
  logic [3:0]                     bpos;
  logic                           last;
  logic                           slot_free;
  logic                           advance;
  logic [3:0]                     idx;
  logic [p2c_pkg::EntryW-1:0]     raw;
  logic [3:0]                     o_idx;
  logic [7:0]                     o_red;
  logic [7:0]                     o_green;
  logic [7:0]                     o_blue;
  logic                           o_last;

  assign slot_free = !ov || out.ready;
  assign advance   = pop_valid && slot_free;
  assign pop_ready = slot_free && last;

  always_comb begin
    bpos = pop_data.dbl ? ~cnt[4:1] : ~cnt[3:0];
    last = pop_data.dbl ? (&cnt) : (&cnt[3:0]);
    idx  = {pop_data.w3[bpos], pop_data.w2[bpos], pop_data.w1[bpos], pop_data.w0[bpos]};
    raw  = p2c_pkg::raw_entry(pal, idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov  <= 1'b0;
      cnt <= '0;
    end else begin
      if (advance) begin
        ov  <= 1'b1;
        cnt <= last ? 5'd0 : cnt + 5'd1;
      end else if (out.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_idx   <= idx;
      o_red   <= p2c_pkg::gun_level(raw[11:8], enhanced);
      o_green <= p2c_pkg::gun_level(raw[7:4], enhanced);
      o_blue  <= p2c_pkg::gun_level(raw[3:0], enhanced);
      o_last  <= last;
    end
  end

  assign out.valid       = ov;
  assign out.pixel_index = o_idx;
  assign out.red_level   = o_red;
  assign out.green_level = o_green;
  assign out.blue_level  = o_blue;
  assign out.last_pixel  = o_last;

endmodule

`default_nettype wire
